/* design/vrse_pkg.sv */
package vrse_pkg;
   localparam int MaxItems  = 1024;
   localparam int AddrWidth = $clog2(MaxItems);
   localparam int CntWidth  = $clog2(MaxItems + 1);
   localparam int ValWidth  = 31;
   localparam int SumWidth  = 41;
   localparam int BndWidth  = 32;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;
endpackage

/* design/value_range_sum_engine_unit.sv */
// Load: insertion sort, one memory shift per read/compare state pair.
// Closing load adds a running-sum pass over the sorted values.
// Query on a closed set: two binary searches of up to log2(MaxItems)+1 steps,
// each a read and a compare state, plus two sum reads. One transaction at a time.
// Synchronous reset clears the count and flags; memory contents stay undefined.
// The result strobe lasts one cycle; the receiver cannot stall.
module value_range_sum_engine_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_command,
   input  logic [vrse_pkg::ValWidth-1:0] req_item_value,
   input  logic                         req_last_item,
   input  logic signed [vrse_pkg::BndWidth-1:0] req_bound_a,
   input  logic signed [vrse_pkg::BndWidth-1:0] req_bound_b,
   output logic                         rsp_valid,
   output logic [vrse_pkg::SumWidth-1:0] rsp_range_sum,
   output logic                         rsp_status
);
   import vrse_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_INS_RD, S_INS_CMP, S_PS_RD, S_PS_WR,
      S_BS_RD, S_BS_CMP, S_SUM_RD, S_SUM_W1, S_SUM_W2, S_DONE
   } state_type;

   state_type            state_ff;
   logic [CntWidth-1:0]  count_ff;
   logic                 closed_ff, ovf_ff, build_ff;
   logic [ValWidth-1:0]  val_ff;
   logic [CntWidth-1:0]  idx_ff;           // insertion position / sum index
   logic [SumWidth-1:0]  acc_ff;
   logic signed [BndWidth:0] lim_ff, hi_ff; // search limit, lower bound minus one
   logic                 pass_ff;           // 0: hi search, 1: lo-1 search
   logic [CntWidth-1:0]  lo_ff, hi_ix_ff, k_hi_ff, k_lo_ff;
   logic [SumWidth-1:0]  s_hi_ff;
   logic [SumWidth-1:0]  rsp_sum_ff;
   logic                 rsp_status_ff;

   // memory port control
   logic                 val_we, sum_we;
   logic [AddrWidth-1:0] val_waddr, val_raddr, sum_waddr, sum_raddr;
   logic [ValWidth-1:0]  val_wdata, val_rdata;
   logic [SumWidth-1:0]  sum_wdata, sum_rdata;
   logic [CntWidth-1:0]  mid;

   assign mid = lo_ff + ((hi_ix_ff - lo_ff) >> 1);

   always_comb begin
      val_we    = 1'b0;
      val_waddr = idx_ff[AddrWidth-1:0];
      val_wdata = val_ff;
      val_raddr = mid[AddrWidth-1:0];
      sum_we    = 1'b0;
      sum_waddr = idx_ff[AddrWidth-1:0];
      sum_wdata = acc_ff + SumWidth'(val_rdata);
      sum_raddr = k_hi_ff[AddrWidth-1:0] - AddrWidth'(1);
      unique case (state_ff)
         S_INS_RD: val_raddr = idx_ff[AddrWidth-1:0] - AddrWidth'(1);
         S_INS_CMP: begin
            val_we = 1'b1;
            // shift the larger neighbour up, or drop the new value in place
            if (idx_ff != '0 && val_rdata > val_ff) val_wdata = val_rdata;
         end
         S_PS_RD:  val_raddr = idx_ff[AddrWidth-1:0];
         S_PS_WR:  sum_we = 1'b1;
         S_SUM_W1: sum_raddr = k_lo_ff[AddrWidth-1:0] - AddrWidth'(1);
         default: ;
      endcase
   end

   vrse_store u_store (
      .clock(clock),
      .val_we(val_we), .val_waddr(val_waddr), .val_wdata(val_wdata),
      .val_raddr(val_raddr), .val_rdata(val_rdata),
      .sum_we(sum_we), .sum_waddr(sum_waddr), .sum_wdata(sum_wdata),
      .sum_raddr(sum_raddr), .sum_rdata(sum_rdata)
   );

   // the result is presented for the single cycle spent in S_DONE
   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = (state_ff == S_DONE);
   assign rsp_range_sum = rsp_sum_ff;
   assign rsp_status    = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         closed_ff    <= 1'b0;
         ovf_ff       <= 1'b0;
         build_ff     <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  if (req_command == CMD_LOAD) begin
                     logic [CntWidth-1:0] cnt;
                     logic                ovf;
                     cnt = closed_ff ? '0 : count_ff;
                     ovf = closed_ff ? 1'b0 : ovf_ff;
                     build_ff  <= req_last_item;
                     val_ff    <= req_item_value;
                     count_ff  <= cnt;
                     acc_ff    <= '0;
                     if (cnt < CntWidth'(MaxItems)) begin
                        closed_ff <= 1'b0;
                        idx_ff    <= cnt;
                        ovf_ff    <= ovf;
                        state_ff  <= S_INS_RD;
                     end else begin
                        closed_ff <= req_last_item;
                        ovf_ff    <= 1'b1;
                        idx_ff    <= '0;
                        state_ff  <= req_last_item ? S_PS_RD : S_IDLE;
                     end
                  end else if (!closed_ff) begin
                     rsp_sum_ff    <= '0;
                     rsp_status_ff <= ovf_ff;
                     state_ff      <= S_DONE;
                  end else begin
                     logic signed [BndWidth:0] a, b;
                     a = {req_bound_a[BndWidth-1], req_bound_a};
                     b = {req_bound_b[BndWidth-1], req_bound_b};
                     lim_ff   <= (a < b) ? b : a;
                     hi_ff    <= (a < b) ? a - 1 : b - 1;
                     pass_ff  <= 1'b0;
                     lo_ff    <= '0;
                     hi_ix_ff <= count_ff;
                     state_ff <= S_BS_RD;
                  end
               end
            end
            S_INS_RD: state_ff <= S_INS_CMP;
            S_INS_CMP: begin
               if (idx_ff != '0 && val_rdata > val_ff) begin
                  idx_ff   <= idx_ff - CntWidth'(1);
                  state_ff <= S_INS_RD;
               end else begin
                  count_ff <= count_ff + CntWidth'(1);
                  idx_ff   <= '0;
                  if (build_ff) begin
                     closed_ff <= 1'b1;
                     state_ff  <= S_PS_RD;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_PS_RD: state_ff <= (idx_ff < count_ff) ? S_PS_WR : S_IDLE;
            S_PS_WR: begin
               acc_ff   <= sum_wdata;
               idx_ff   <= idx_ff + CntWidth'(1);
               state_ff <= S_PS_RD;
            end
            S_BS_RD: begin
               if (lo_ff < hi_ix_ff) state_ff <= S_BS_CMP;
               else if (!pass_ff) begin
                  k_hi_ff  <= lo_ff;
                  pass_ff  <= 1'b1;
                  lim_ff   <= hi_ff;
                  lo_ff    <= '0;
                  hi_ix_ff <= count_ff;
               end else begin
                  k_lo_ff  <= lo_ff;
                  state_ff <= S_SUM_RD;
               end
            end
            S_BS_CMP: begin
               if ($signed({2'b00, val_rdata}) <= lim_ff) lo_ff <= mid + CntWidth'(1);
               else hi_ix_ff <= mid;
               state_ff <= S_BS_RD;
            end
            S_SUM_RD: state_ff <= S_SUM_W1;
            S_SUM_W1: begin
               s_hi_ff  <= (k_hi_ff == '0) ? '0 : sum_rdata;
               state_ff <= S_SUM_W2;
            end
            S_SUM_W2: begin
               rsp_sum_ff    <= (k_hi_ff > k_lo_ff)
                                ? s_hi_ff - ((k_lo_ff == '0) ? '0 : sum_rdata) : '0;
               rsp_status_ff <= ovf_ff;
               state_ff      <= S_DONE;
            end
            S_DONE:  state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

/* design/vrse_store.sv */
// Holds the sorted values and the running sums, one write port and one read port each.
module vrse_store (
   input  logic                          clock,
   input  logic                          val_we,
   input  logic [vrse_pkg::AddrWidth-1:0] val_waddr,
   input  logic [vrse_pkg::ValWidth-1:0]  val_wdata,
   input  logic [vrse_pkg::AddrWidth-1:0] val_raddr,
   output logic [vrse_pkg::ValWidth-1:0]  val_rdata,
   input  logic                          sum_we,
   input  logic [vrse_pkg::AddrWidth-1:0] sum_waddr,
   input  logic [vrse_pkg::SumWidth-1:0]  sum_wdata,
   input  logic [vrse_pkg::AddrWidth-1:0] sum_raddr,
   output logic [vrse_pkg::SumWidth-1:0]  sum_rdata
);
   import vrse_pkg::*;

   logic [ValWidth-1:0] val_mem [MaxItems];
   logic [SumWidth-1:0] sum_mem [MaxItems];

   always_ff @(posedge clock) begin
      if (val_we) val_mem[val_waddr] <= val_wdata;
      val_rdata <= val_mem[val_raddr];
   end

   always_ff @(posedge clock) begin
      if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
      sum_rdata <= sum_mem[sum_raddr];
   end
endmodule

/* verif/tb_value_range_sum_engine_unit.sv */
module tb_value_range_sum_engine_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import vrse_pkg::*;

   // Mirror of the engine: a multiset of held values, checked by direct scan.
   class range_sum_board;
      bit [ValWidth-1:0] held_values[$];
      bit                set_closed;
      bit                overflow_seen;
      bit [SumWidth-1:0] expected_sums[$];
      bit                expected_status[$];
      int                error_count;

      function void note_transaction(bit cmd, bit [ValWidth-1:0] val, bit last,
                                     bit signed [BndWidth-1:0] ba,
                                     bit signed [BndWidth-1:0] bb);
         longint lo;
         longint hi;
         longint v;
         bit [63:0] acc;
         if (cmd == CMD_LOAD) begin
            // a load after closing starts a fresh set
            if (set_closed) begin
               held_values.delete();
               set_closed    = 0;
               overflow_seen = 0;
            end
            if (held_values.size() < MaxItems) held_values.push_back(val);
            else overflow_seen = 1;
            if (last) set_closed = 1;
         end else begin
            acc = 0;
            if (set_closed) begin
               lo = (ba < bb) ? longint'(ba) : longint'(bb);
               hi = (ba < bb) ? longint'(bb) : longint'(ba);
               foreach (held_values[i]) begin
                  v = longint'(held_values[i]);
                  if (v >= lo && v <= hi) acc += v;
               end
               if (acc > 64'h1FF_FFFF_FFFF) acc = 64'h1FF_FFFF_FFFF;
            end
            expected_sums.push_back(acc[SumWidth-1:0]);
            expected_status.push_back(overflow_seen);
         end
      endfunction

      function void check_result(bit [SumWidth-1:0] sum, bit status);
         bit [SumWidth-1:0] exp_sum;
         bit                exp_status;
         if (expected_sums.size() == 0) begin
            $display("%0t: unexpected result sum=%0d status=%0d", $time, sum, status);
            error_count++;
            return;
         end
         exp_sum    = expected_sums.pop_front();
         exp_status = expected_status.pop_front();
         if (sum !== exp_sum) begin
            $display("%0t: range_sum expected %0d actual %0d", $time, exp_sum, sum);
            error_count++;
         end
         if (status !== exp_status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_status, status);
            error_count++;
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic                       req_command;
   logic [ValWidth-1:0]        req_item_value;
   logic                       req_last_item;
   logic signed [BndWidth-1:0] req_bound_a;
   logic signed [BndWidth-1:0] req_bound_b;
   logic                       rsp_valid;
   logic [SumWidth-1:0]        rsp_range_sum;
   logic                       rsp_status;

   range_sum_board board;
   longint         cycle_count = 0;
   bit [ValWidth-1:0] recent_values[$];

   value_range_sum_engine_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_item_value (req_item_value),
      .req_last_item  (req_last_item),
      .req_bound_a    (req_bound_a),
      .req_bound_b    (req_bound_b),
      .rsp_valid      (rsp_valid),
      .rsp_range_sum  (rsp_range_sum),
      .rsp_status     (rsp_status)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Check every strobed result at the edge that accepts it.
   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_result(rsp_range_sum, rsp_status);
   end

   // Generous watchdog, sized for the worst-case filling of a full set.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 64'd20_000_000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Drive one transaction after a random gap, hold until accepted.
   task automatic send_transaction(bit cmd, bit [ValWidth-1:0] val, bit last,
                                   bit [BndWidth-1:0] ba, bit [BndWidth-1:0] bb);
      int gap;
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) gap = 0;
      // step off the previous accepting edge; the engine is still busy there
      @(posedge clock);
      repeat (gap) @(posedge clock);
      start          <= 1;
      req_command    <= cmd;
      req_item_value <= val;
      req_last_item  <= last;
      req_bound_a    <= ba;
      req_bound_b    <= bb;
      // advance until the engine takes it
      do @(posedge clock); while (busy);
      board.note_transaction(cmd, val, last, ba, bb);
      start <= 0;
      // scramble bits the engine should ignore while idle
      req_item_value <= ValWidth'($urandom);
      req_last_item  <= 1'($urandom);
   endtask

   // Pick a value: extremes, small values, recent loads, or random.
   function automatic bit [ValWidth-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return ValWidth'($urandom_range(0, 100));
         3: return (recent_values.size() > 0)
                   ? recent_values[$urandom_range(0, recent_values.size() - 1)] : '0;
         default: return ValWidth'($urandom);
      endcase
   endfunction

   function automatic bit [BndWidth-1:0] pick_bound();
      bit [BndWidth-1:0] b;
      case ($urandom_range(0, 6))
         0: b = 32'h8000_0000;
         1: b = 32'h7FFF_FFFF;
         2: b = $urandom_range(0, 3) - 2;
         3, 4: begin
            b = (recent_values.size() > 0)
                ? BndWidth'(recent_values[$urandom_range(0, recent_values.size() - 1)])
                : '0;
            b = b + $urandom_range(0, 2) - 1;
         end
         default: b = $urandom;
      endcase
      return b;
   endfunction

   task automatic send_load(bit [ValWidth-1:0] val, bit last);
      recent_values.push_back(val);
      if (recent_values.size() > 32) void'(recent_values.pop_front());
      send_transaction(CMD_LOAD, val, last, $urandom, $urandom);
   endtask

   task automatic send_query(bit [BndWidth-1:0] ba, bit [BndWidth-1:0] bb);
      send_transaction(CMD_QUERY, ValWidth'($urandom), 1'($urandom), ba, bb);
   endtask

   task automatic drain();
      while (board.expected_sums.size() > 0) @(posedge clock);
   endtask

   initial begin
      int sent;
      int set_size;
      board          = new();
      reset          = 1;
      start          = 0;
      req_command    = CMD_LOAD;
      req_item_value = '0;
      req_last_item  = 0;
      req_bound_a    = '0;
      req_bound_b    = '0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: query before any set is closed, then a small set with extremes.
      send_query(32'h8000_0000, 32'h7FFF_FFFF);
      send_load(31'h7FFF_FFFF, 0);
      send_load('0, 0);
      send_query(0, 100);                      // query while the set is still open
      send_load(5, 0);
      send_load(5, 1);
      send_query(32'h8000_0000, 32'h7FFF_FFFF); // whole range
      send_query(32'h7FFF_FFFF, 32'h8000_0000); // reversed bounds
      send_query(5, 5);
      send_query(6, 100);                       // nothing in range
      send_query(32'hFFFF_FFFF, 32'hFFFF_FFFF); // negative only
      send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_query(32'hFFFF_FFFF, 0);
      send_load(7, 1);                          // load after closing: new single set
      send_query(0, 10);
      send_query(7, 7);
      sent = 16;

      // Overflow: fill past capacity, closing flag on a dropped load.
      drain();
      for (int i = 0; i < MaxItems + 3; i++)
         send_load((i % 3 == 0) ? pick_value() : ValWidth'($urandom_range(0, 50000)),
                   i == MaxItems + 2);
      send_query(32'h8000_0000, 32'h7FFF_FFFF);
      send_query(pick_bound(), pick_bound());
      send_query(0, 25000);
      send_load(9, 1);                          // new set clears the flag
      send_query(0, 9);
      sent += MaxItems + 8;

      // Random: mostly small sets followed by queries, plus some noise.
      while (sent < 1550) begin
         if ($urandom_range(0, 7) == 0) begin
            send_query(pick_bound(), pick_bound());
            sent++;
            continue;
         end
         set_size = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40)
                                                : $urandom_range(1, 8);
         for (int i = 0; i < set_size; i++) begin
            send_load(pick_value(), (i == set_size - 1) && ($urandom_range(0, 9) != 0));
            sent++;
         end
         repeat ($urandom_range(2, 10)) begin
            send_query(pick_bound(), pick_bound());
            sent++;
         end
         // hold the sender until every pending answer is back
         if ($urandom_range(0, 19) == 0) drain();
      end

      drain();
      repeat (200) @(posedge clock);
      if (board.error_count == 0 && board.expected_sums.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
